// ===== rtl/rolling_zscore_threshold_signal_defines.svh =====
// Assertion macros used by the checker of the rolling z-score block.
`ifndef ROLLING_ZSCORE_THRESHOLD_SIGNAL_DEFINES_SVH
`define ROLLING_ZSCORE_THRESHOLD_SIGNAL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RZTS_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rzts check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RZTS_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rzts check failed");

`endif

// ===== rtl/rzts_pkg.sv =====
`timescale 1ns / 1ps

package rzts_pkg;

  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int WLEN_W     = 7;
  localparam int ELVL_W     = 12;
  localparam int HLEN_W     = 8;

  // Compare scale: the threshold carries 8 fraction bits, squared gives 16.
  localparam int LHS_SHIFT = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_LEN    = 2'd2;

  localparam logic [WLEN_W-1:0] WINDOW_LEN_RST  = 7'd20;
  localparam logic [ELVL_W-1:0] ENTRY_LEVEL_RST = 12'd256;
  localparam logic [HLEN_W-1:0] HOLD_LEN_RST    = 8'd5;

  localparam logic signed [1:0] SIG_NONE = 2'sb00;
  localparam logic signed [1:0] SIG_BUY  = 2'sb01;
  localparam logic signed [1:0] SIG_SELL = 2'sb11;

  // Datapath step issued by the controller each cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQX,
    OP_SQO,
    OP_SUB,
    OP_VAR,
    OP_DSQ,
    OP_RLO,
    OP_RHI,
    OP_SUMR,
    OP_FINISH
  } dp_op_t;

endpackage

// ===== rtl/rzts_ctrl.sv =====
`timescale 1ns / 1ps

module rzts_ctrl
  import rzts_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  output logic   out_valid,
  input  logic   out_ready,
  output dp_op_t dp_op
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQO,
    ST_SUB,
    ST_VAR,
    ST_DSQ,
    ST_RLO,
    ST_RHI,
    ST_SUMR,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    dp_op         = OP_NONE;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          dp_op     = OP_LOAD;
          state_nxt = ST_SQX;
        end
      end
      ST_SQX: begin
        dp_op     = OP_SQX;
        state_nxt = ST_SQO;
      end
      ST_SQO: begin
        dp_op     = OP_SQO;
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        dp_op     = OP_SUB;
        state_nxt = ST_VAR;
      end
      ST_VAR: begin
        dp_op     = OP_VAR;
        state_nxt = ST_DSQ;
      end
      ST_DSQ: begin
        dp_op     = OP_DSQ;
        state_nxt = ST_RLO;
      end
      ST_RLO: begin
        dp_op     = OP_RLO;
        state_nxt = ST_RHI;
      end
      ST_RHI: begin
        dp_op     = OP_RHI;
        state_nxt = ST_SUMR;
      end
      ST_SUMR: begin
        dp_op     = OP_SUMR;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          dp_op         = OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/rzts_dp.sv =====
`timescale 1ns / 1ps

module rzts_dp
  import rzts_pkg::*;
#(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_op_t                dp_op,
  input  logic [PRICE_BITS-1:0] in_price,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic signed [1:0]     out_signal,
  output logic                  out_window_full
);

  localparam int WB     = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int SUM_W  = PRICE_BITS + $clog2(MAX_WINDOW);
  localparam int SQ_W   = 2 * PRICE_BITS + $clog2(MAX_WINDOW);
  localparam int VAR_W  = 2 * SUM_W;
  localparam int VH_W   = (VAR_W + 1) / 2;
  localparam int T2_W   = 2 * ELVL_W;
  localparam int MUL_A  = (SUM_W > VH_W) ? SUM_W : VH_W;
  localparam int MUL_B  = (PRICE_BITS > T2_W) ? PRICE_BITS : T2_W;
  localparam int MUL_W  = (MUL_A > MUL_B) ? MUL_A : MUL_B;
  localparam int PROD_W = 2 * MUL_W;
  localparam int LHS_W  = 2 * SUM_W;
  localparam int RHS_W  = PROD_W + VH_W + 1;
  localparam int CMP_W  = (RHS_W > LHS_W + LHS_SHIFT) ? RHS_W : LHS_W + LHS_SHIFT;
  localparam int CW     = (WLEN_W > WB) ? WLEN_W : WB;
  localparam int WX_W   = WB + PRICE_BITS;

  logic [PRICE_BITS-1:0] ring_mem [MAX_WINDOW];

  // configuration and window state
  logic [WLEN_W-1:0] win_len_r;
  logic [ELVL_W-1:0] entry_lvl_r;
  logic [HLEN_W-1:0] hold_len_r;
  logic [SLOT_W-1:0] slot_r;
  logic [WB-1:0]     seen_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SQ_W-1:0]   sumsq_r;
  logic [HLEN_W-1:0] hold_r;

  // per-beat work registers
  logic [PRICE_BITS-1:0] x_r;
  logic [PRICE_BITS-1:0] old_r;
  logic                  evict_r;
  logic                  full_r;
  logic [PROD_W-1:0]     prod_r;
  logic [SUM_W-1:0]      wx_r;
  logic [VAR_W-1:0]      wq_r;
  logic [VAR_W-1:0]      ss_r;
  logic [SUM_W-1:0]      ad_r;
  logic                  pos_r;
  logic [T2_W-1:0]       t2_r;
  logic [VAR_W-1:0]      var_r;
  logic                  vpos_r;
  logic [LHS_W-1:0]      lhs_r;
  logic [PROD_W-1:0]     rlo_r;
  logic [RHS_W-1:0]      rhs_r;
  logic signed [1:0]     sig_r;
  logic                  full_out_r;

  logic [CW-1:0]     wl_ext;
  logic [WB-1:0]     w_eff;
  logic [SLOT_W-1:0] slot_use;
  logic [WB-1:0]     slot_inc;
  logic [SLOT_W-1:0] slot_nxt;
  logic [WB-1:0]     seen_nxt;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [WX_W-1:0]   wx_full;
  logic [CMP_W-1:0]  lhs_cmp;
  logic              over_lvl;
  logic              restart;

  // clamp the window length to [2, MAX_WINDOW]
  assign wl_ext = CW'(win_len_r);
  always_comb begin
    if (wl_ext < CW'(2)) begin
      w_eff = WB'(2);
    end else if (wl_ext > CW'(MAX_WINDOW)) begin
      w_eff = WB'(MAX_WINDOW);
    end else begin
      w_eff = wl_ext[WB-1:0];
    end
  end

  assign slot_use = (WB'(slot_r) < w_eff) ? slot_r : '0;
  assign slot_inc = WB'(slot_use) + WB'(1);
  assign slot_nxt = (slot_inc >= w_eff) ? '0 : slot_inc[SLOT_W-1:0];
  assign seen_nxt = (seen_r < w_eff) ? seen_r + WB'(1) : seen_r;

  assign restart = cfg_we && (cfg_index == REG_WINDOW_LEN);

  // shared multiplier operand select
  always_comb begin
    case (dp_op)
      OP_SQX: begin
        mul_a = MUL_W'(x_r);
        mul_b = MUL_W'(x_r);
      end
      OP_SQO: begin
        mul_a = MUL_W'(old_r);
        mul_b = MUL_W'(old_r);
      end
      OP_SUB: begin
        mul_a = MUL_W'(sum_r);
        mul_b = MUL_W'(sum_r);
      end
      OP_DSQ: begin
        mul_a = MUL_W'(ad_r);
        mul_b = MUL_W'(ad_r);
      end
      OP_RLO: begin
        mul_a = MUL_W'(t2_r);
        mul_b = MUL_W'(var_r[VH_W-1:0]);
      end
      OP_RHI: begin
        mul_a = MUL_W'(t2_r);
        mul_b = MUL_W'(var_r[VAR_W-1:VH_W]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign wx_full  = WX_W'(w_eff) * WX_W'(x_r);
  assign lhs_cmp  = CMP_W'(lhs_r) << LHS_SHIFT;
  assign over_lvl = lhs_cmp > CMP_W'(rhs_r);

  // sample ring: read the evicted entry and write the new beat on the same edge
  always_ff @(posedge clk) begin
    if (dp_op == OP_LOAD) begin
      old_r              <= ring_mem[slot_use];
      ring_mem[slot_use] <= in_price;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= WINDOW_LEN_RST;
      entry_lvl_r <= ENTRY_LEVEL_RST;
      hold_len_r  <= HOLD_LEN_RST;
      slot_r      <= '0;
      seen_r      <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      hold_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LEN:  win_len_r   <= cfg_wdata[WLEN_W-1:0];
        REG_ENTRY_LEVEL: entry_lvl_r <= cfg_wdata[ELVL_W-1:0];
        REG_HOLD_LEN:    hold_len_r  <= cfg_wdata[HLEN_W-1:0];
        default: ;
      endcase
      if (restart) begin
        slot_r  <= '0;
        seen_r  <= '0;
        sum_r   <= '0;
        sumsq_r <= '0;
      end
    end else begin
      case (dp_op)
        OP_LOAD: begin
          slot_r <= slot_nxt;
          seen_r <= seen_nxt;
        end
        OP_SQX: begin
          sum_r <= sum_r + SUM_W'(x_r) - (evict_r ? SUM_W'(old_r) : '0);
        end
        OP_SQO: begin
          sumsq_r <= sumsq_r + SQ_W'(prod_r);
        end
        OP_SUB: begin
          sumsq_r <= sumsq_r - (evict_r ? SQ_W'(prod_r) : '0);
        end
        OP_FINISH: begin
          if (hold_r != '0) begin
            hold_r <= hold_r - HLEN_W'(1);
          end else if (full_r && vpos_r && (ad_r != '0) && over_lvl) begin
            hold_r <= hold_len_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    case (dp_op)
      OP_LOAD: begin
        x_r     <= in_price;
        evict_r <= (seen_r >= w_eff);
        full_r  <= (seen_nxt >= w_eff);
      end
      OP_SUB: begin
        wx_r <= wx_full[SUM_W-1:0];
      end
      OP_VAR: begin
        wq_r  <= VAR_W'(w_eff) * VAR_W'(sumsq_r);
        ss_r  <= VAR_W'(prod_r);
        pos_r <= (wx_r > sum_r);
        ad_r  <= (wx_r > sum_r) ? (wx_r - sum_r) : (sum_r - wx_r);
        t2_r  <= T2_W'(entry_lvl_r) * T2_W'(entry_lvl_r);
      end
      OP_DSQ: begin
        vpos_r <= (wq_r > ss_r);
        var_r  <= wq_r - ss_r;
      end
      OP_RLO: begin
        lhs_r <= prod_r[LHS_W-1:0];
      end
      OP_RHI: begin
        rlo_r <= prod_r;
      end
      OP_SUMR: begin
        // upper partial carries the weight of the lower var half
        rhs_r <= (RHS_W'(prod_r) << VH_W) + RHS_W'(rlo_r);
      end
      OP_FINISH: begin
        full_out_r <= full_r;
        if (hold_r == '0 && full_r && vpos_r && (ad_r != '0) && over_lvl) begin
          sig_r <= pos_r ? SIG_SELL : SIG_BUY;
        end else begin
          sig_r <= SIG_NONE;
        end
      end
      default: ;
    endcase
  end

  assign out_signal      = sig_r;
  assign out_window_full = full_out_r;

endmodule

// ===== rtl/rolling_zscore_threshold_signal.sv =====
`timescale 1ns / 1ps
// Steps: an accepted beat passes SQX, SQO, SUB, VAR, DSQ, RLO, RHI, SUMR and
// DONE; out_valid is registered as DONE completes. A price beat is taken
// only in IDLE, after the fixed step sequence that routes six products
// through the single shared multiplier; an unread result stalls only DONE.
// Reset: synchronous, active low; clears window state, sums, hold count and
// loads register defaults; the sample ring is not cleared and needs no pass.

module rolling_zscore_threshold_signal
  import rzts_pkg::*;
#(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PRICE_BITS-1:0] in_price,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [1:0]     out_signal,
  output logic                  out_window_full,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_op_t dp_op;

  rzts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_op     (dp_op)
  );

  rzts_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .dp_op           (dp_op),
    .in_price        (in_price),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_signal      (out_signal),
    .out_window_full (out_window_full)
  );

endmodule

// ===== rtl/rzts_checker.sv =====
`timescale 1ns / 1ps
`include "rolling_zscore_threshold_signal_defines.svh"

module rzts_checker
  import rzts_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [1:0] out_signal,
  input logic              out_window_full
);

  logic out_stall;
  logic sig_legal;
  logic trade_out;

  assign out_stall = out_valid && !out_ready;
  assign sig_legal = (out_signal == SIG_NONE) || (out_signal == SIG_BUY) ||
                     (out_signal == SIG_SELL);
  assign trade_out = out_valid && (out_signal != SIG_NONE);

  // a stalled result beat holds its payload
  `RZTS_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, $stable({out_signal, out_window_full}))

  // only the three legal signal codes leave the block
  `RZTS_ASSERT_IMP(a_sig_code, clk, rst_n, out_valid, sig_legal)

  // a trade is only called on a full window
  `RZTS_ASSERT_IMP(a_sig_full, clk, rst_n, trade_out, out_window_full)

  // one beat at a time: input closes right after an accept
  `RZTS_ASSERT_NXT(a_one_beat, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind rolling_zscore_threshold_signal rzts_checker u_rzts_checker (.*);
